// ----- rtl/core/bpa_pkg.sv -----
// Shared constants, item kinds and controller/datapath interface types of the page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

	localparam int DEF_NUM_PAGES  = 1024;
	localparam int DEF_PAGE_BYTES = 4096;
	localparam int WORD_BITS      = 32;
	localparam int IN_WORD_BITS   = 65;

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_ZONE  = 2'd2;

	typedef struct packed {
		logic capture;
		logic w_clr;
		logic w_inc;
		logic use_page;
		logic mem_rd;
		logic clr_wr;
		logic alloc_wr;
		logic free_wr;
		logic zone_n;
		logic zone_e;
		logic zone_h;
		logic zone_mask;
		logic zone_wr;
		logic res_set;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic w_last;
		logic alloc_none;
		logic found;
		logic page_oob;
	} stat_t;

endpackage

// ----- rtl/core/bpa_dpath.sv -----
// Datapath of the page allocator: used-map memory, scan word counter, zone bounds and results.
`timescale 1ns / 1ps

module bpa_dpath #(
	parameter int NUM_PAGES  = bpa_pkg::DEF_NUM_PAGES,
	parameter int PAGE_BYTES = bpa_pkg::DEF_PAGE_BYTES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [bpa_pkg::IN_WORD_BITS-1:0]  in_word,
	input  bpa_pkg::cmd_t                     cmd,
	output bpa_pkg::stat_t                    stat,
	output logic [31:0]                       out_addr,
	output logic                              out_grant
);
	import bpa_pkg::*;

	// PAGE_BYTES is a power of two, so page numbers are address shifts.
	localparam int SHIFT     = $clog2(PAGE_BYTES);
	localparam int PW        = 32 - SHIFT;
	localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CNTW      = $clog2(NUM_PAGES + 1);
	localparam int UW_A      = (PW + 1 > WAW + 5) ? PW + 1 : WAW + 5;
	localparam int UW        = (UW_A > CNTW) ? UW_A : CNTW;
	localparam logic [PW:0] P_VAL = {1'b1, {PW{1'b0}}};

	logic [31:0]     map_mem [MAP_WORDS];
	logic [31:0]     rdata_q;
	logic [31:0]     addr_q;
	logic [31:0]     len_q;
	logic            avail_q;
	logic [WAW-1:0]  w_q;
	logic [CNTW-1:0] managed_q;
	logic [PW:0]     n_q;
	logic [PW:0]     end_q;
	logic [UW-1:0]   hi1_q;
	logic [UW-1:0]   hi2_q;
	logic [31:0]     mask_q;
	logic [31:0]     res_addr_q;
	logic            res_grant_q;
	logic [31:0]     out_addr_q;
	logic            out_grant_q;

	logic [UW-1:0]   wb;
	logic [PW-1:0]   bp;
	logic [UW-1:0]   page_ext;
	logic [WAW-1:0]  mem_idx;
	logic [5:0]      lim;
	logic [31:0]     free_bits;
	logic [31:0]     low_bit;
	logic [4:0]      idx;
	logic [WAW+4:0]  pnum;
	logic [31:0]     alloc_addr;
	logic [32:0]     nsum;
	logic [UW:0]     total;
	logic [PW:0]     hi1_raw;
	logic [PW:0]     hi2_raw;
	logic [31:0]     zone_mask_d;
	logic            mem_we;
	logic [31:0]     mem_wdata;

	// Number of bits of a word that lie below bound a, counted from word base b.
	function automatic logic [5:0] clamp_rel(input logic [UW-1:0] a, input logic [UW-1:0] b);
		logic signed [UW:0] d;
		d = $signed({1'b0, a}) - $signed({1'b0, b});
		if (d <= 0)
			return 6'd0;
		else if (d >= 32)
			return 6'd32;
		else
			return 6'(d);
	endfunction

	function automatic logic [31:0] thermo(input logic [5:0] x);
		return x[5] ? '1 : ((32'd1 << x[4:0]) - 32'd1);
	endfunction

	assign wb       = UW'({w_q, 5'd0});
	assign bp       = addr_q[31:SHIFT];
	assign page_ext = UW'(bp);
	assign mem_idx  = cmd.use_page ? page_ext[WAW+4:5] : w_q;

	assign lim       = clamp_rel(UW'(managed_q), wb);
	assign free_bits = ~rdata_q & thermo(lim);
	assign low_bit   = free_bits & (~free_bits + 32'd1);

	always_comb begin
		idx = '0;
		for (int i = 0; i < 32; i++) begin
			if (low_bit[i])
				idx = idx | 5'(i);
		end
	end

	assign pnum       = {w_q, idx};
	assign alloc_addr = 32'(pnum) << SHIFT;

	assign nsum    = {1'b0, len_q} + 33'(PAGE_BYTES - 1);
	assign total   = (UW + 1)'(managed_q) + (UW + 1)'(n_q);
	assign hi1_raw = (end_q > P_VAL) ? P_VAL : end_q;
	assign hi2_raw = (end_q > P_VAL) ? end_q - P_VAL : '0;

	assign zone_mask_d = (thermo(clamp_rel(hi1_q, wb)) & ~thermo(clamp_rel(page_ext, wb)))
		| thermo(clamp_rel(hi2_q, wb));

	assign stat.w_last     = (w_q == WAW'(MAP_WORDS - 1));
	assign stat.alloc_none = (lim == 6'd0);
	assign stat.found      = |free_bits;
	assign stat.page_oob   = (page_ext >= UW'(NUM_PAGES));

	always_comb begin
		mem_we    = cmd.clr_wr | cmd.alloc_wr | cmd.free_wr | cmd.zone_wr;
		mem_wdata = '1;
		if (cmd.alloc_wr)
			mem_wdata = rdata_q | low_bit;
		else if (cmd.free_wr)
			mem_wdata = rdata_q & ~(32'd1 << page_ext[4:0]);
		else if (cmd.zone_wr)
			mem_wdata = avail_q ? (rdata_q & ~mask_q) : (rdata_q | mask_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			map_mem[mem_idx] <= mem_wdata;
		if (cmd.mem_rd)
			rdata_q <= map_mem[mem_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= '0;
			managed_q <= '0;
		end else begin
			if (cmd.w_clr)
				w_q <= '0;
			else if (cmd.w_inc)
				w_q <= w_q + WAW'(1);
			if (cmd.zone_e) begin
				if (total > (UW + 1)'(NUM_PAGES))
					managed_q <= CNTW'(NUM_PAGES);
				else
					managed_q <= CNTW'(total);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q      <= in_word[31:0];
			len_q       <= in_word[63:32];
			avail_q     <= in_word[64];
			res_addr_q  <= '0;
			res_grant_q <= 1'b0;
		end
		if (cmd.res_set) begin
			res_addr_q  <= alloc_addr;
			res_grant_q <= 1'b1;
		end
		if (cmd.zone_n)
			n_q <= (PW + 1)'(nsum >> SHIFT);
		if (cmd.zone_e)
			end_q <= (PW + 1)'(bp) + n_q;
		if (cmd.zone_h) begin
			hi1_q <= (UW'(hi1_raw) > UW'(NUM_PAGES)) ? UW'(NUM_PAGES) : UW'(hi1_raw);
			hi2_q <= (UW'(hi2_raw) > UW'(NUM_PAGES)) ? UW'(NUM_PAGES) : UW'(hi2_raw);
		end
		if (cmd.zone_mask)
			mask_q <= zone_mask_d;
		if (cmd.out_load) begin
			out_addr_q  <= res_addr_q;
			out_grant_q <= res_grant_q;
		end
	end

	assign out_addr  = out_addr_q;
	assign out_grant = out_grant_q;

endmodule

// ----- rtl/core/bpa_ctrl.sv -----
// Controller of the page allocator: sequences the clearing pass, scans, frees and zone walks.
`timescale 1ns / 1ps

module bpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [1:0]     s_tuser,
	output logic           m_tvalid,
	input  logic           m_tready,
	output bpa_pkg::cmd_t  cmd,
	input  bpa_pkg::stat_t stat
);
	import bpa_pkg::*;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_A_RD  = 4'd2;
	localparam logic [3:0] S_A_CHK = 4'd3;
	localparam logic [3:0] S_F_RD  = 4'd4;
	localparam logic [3:0] S_F_WR  = 4'd5;
	localparam logic [3:0] S_Z_N   = 4'd6;
	localparam logic [3:0] S_Z_E   = 4'd7;
	localparam logic [3:0] S_Z_H   = 4'd8;
	localparam logic [3:0] S_Z_RD  = 4'd9;
	localparam logic [3:0] S_Z_WR  = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (stat.w_last) begin
					cmd.w_clr = 1'b1;
					state_d   = S_IDLE;
				end else begin
					cmd.w_inc = 1'b1;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					cmd.w_clr   = 1'b1;
					case (s_tuser)
						KIND_ALLOC: state_d = S_A_RD;
						KIND_FREE:  state_d = S_F_RD;
						KIND_ZONE:  state_d = S_Z_N;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_A_RD: begin
				if (stat.alloc_none) begin
					state_d = S_DONE;
				end else begin
					cmd.mem_rd = 1'b1;
					state_d    = S_A_CHK;
				end
			end
			S_A_CHK: begin
				if (stat.found) begin
					cmd.alloc_wr = 1'b1;
					cmd.res_set  = 1'b1;
					state_d      = S_DONE;
				end else if (stat.w_last) begin
					state_d = S_DONE;
				end else begin
					cmd.w_inc = 1'b1;
					state_d   = S_A_RD;
				end
			end
			S_F_RD: begin
				if (stat.page_oob) begin
					state_d = S_DONE;
				end else begin
					cmd.use_page = 1'b1;
					cmd.mem_rd   = 1'b1;
					state_d      = S_F_WR;
				end
			end
			S_F_WR: begin
				cmd.use_page = 1'b1;
				cmd.free_wr  = 1'b1;
				state_d      = S_DONE;
			end
			S_Z_N: begin
				cmd.zone_n = 1'b1;
				state_d    = S_Z_E;
			end
			S_Z_E: begin
				cmd.zone_e = 1'b1;
				state_d    = S_Z_H;
			end
			S_Z_H: begin
				cmd.zone_h = 1'b1;
				state_d    = S_Z_RD;
			end
			S_Z_RD: begin
				cmd.mem_rd    = 1'b1;
				cmd.zone_mask = 1'b1;
				state_d       = S_Z_WR;
			end
			S_Z_WR: begin
				cmd.zone_wr = 1'b1;
				if (stat.w_last) begin
					state_d = S_DONE;
				end else begin
					cmd.w_inc = 1'b1;
					state_d   = S_Z_RD;
				end
			end
			S_DONE: begin
				// The finished word moves to the output register once it is free.
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/bitmap_page_allocator.sv -----
// Top level of the first-fit bitmap page allocator.
// Reset starts a clearing pass, one map word at a time, that marks every page used.
// Allocate reads and checks the map words in order until it finds a free page or runs out of managed words.
// Free reads and rewrites the map word of its page; add-zone walks every map word, one map word per
// read-modify-write pair on the single map memory port. One item is in work at a time;
// the next item is taken while the previous result still waits in the output register.
`timescale 1ns / 1ps

module bitmap_page_allocator #(
	parameter int NUM_PAGES  = bpa_pkg::DEF_NUM_PAGES,
	parameter int PAGE_BYTES = bpa_pkg::DEF_PAGE_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // address[31:0], zone_length[63:32], zone_available[64]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // page_address[31:0]
	output logic        m_tuser    // granted[0]
);
	import bpa_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	bpa_dpath #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (s_tdata[IN_WORD_BITS-1:0]),
		.cmd       (cmd),
		.stat      (stat),
		.out_addr  (m_tdata),
		.out_grant (m_tuser)
	);

endmodule
